>>> rtl/i2cbe_pkg.sv
`default_nettype none

package i2cbe_pkg;

   // bit delay counter width and reset value of the half period register
   localparam int          DelayBitsDefault = 16;
   localparam logic [15:0] HalfPeriodReset  = 16'd5;

   // entries in the queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // command codes as they arrive on the request channel
   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_STOP  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // classified command carried through the queue
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   // bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST1,
      PH_ST2,
      PH_ST3,
      PH_SP1,
      PH_SP2,
      PH_SP3,
      PH_WR_A,
      PH_WR_B,
      PH_WR_C,
      PH_WA1,
      PH_WA2,
      PH_WA3,
      PH_WA4,
      PH_RD_A,
      PH_RD_B
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_bit;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> rtl/i2cbe_front.sv
`default_nettype none

module i2cbe_front (
   input  wire  logic                   req_valid,
   output logic                         req_stall,
   input  wire  i2cbe_pkg::req_type     req_data,
   input  wire  i2cbe_pkg::q_status_type q_status,
   output logic                         push,
   output i2cbe_pkg::entry_type         push_entry
);
   import i2cbe_pkg::*;

   // hold off the request side while the queue has no room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // classify the transaction into a queue entry
   always_comb begin
      push_entry.data_byte = req_data.data_byte;
      push_entry.sda_in    = req_data.sda_in;
      push_entry.cmd       = CMD_NONE;
      if (req_data.cmd_valid) begin
         case (action_type'(req_data.action))
            ACT_START: push_entry.cmd = CMD_START;
            ACT_STOP:  push_entry.cmd = CMD_STOP;
            ACT_WRITE: push_entry.cmd = CMD_WRITE;
            ACT_READ:  push_entry.cmd = CMD_READ;
            default:   push_entry.cmd = CMD_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/i2cbe_queue.sv
`default_nettype none

module i2cbe_queue (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   push,
   input  wire  i2cbe_pkg::entry_type   push_entry,
   input  wire  logic                   pop,
   output i2cbe_pkg::entry_type         pop_entry,
   output i2cbe_pkg::q_status_type      q_status
);
   import i2cbe_pkg::*;

   entry_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry          = slot_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == QueueCntW'(QueueDepth));
   assign q_status.not_empty = (count_ff != '0);

endmodule

`default_nettype wire

>>> rtl/i2cbe_back.sv
`default_nettype none

module i2cbe_back #(
   parameter int DELAY_BITS = i2cbe_pkg::DelayBitsDefault
) (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic [15:0]             half_period,
   input  wire  i2cbe_pkg::q_status_type q_status,
   input  wire  i2cbe_pkg::entry_type    pop_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire  logic                    rsp_stall,
   output i2cbe_pkg::rsp_type            rsp_data
);
   import i2cbe_pkg::*;

   localparam logic [31:0] DelayMask =
      (DELAY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DELAY_BITS) - 32'd1);

   phase_type             phase_ff, phase_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic [DELAY_BITS-1:0] hold_ff, hold_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in_lvl;
   logic                  ack_ff, ack_in;
   logic                  busy_ff, busy_in;
   logic [7:0]            read_ff, read_in;
   logic                  done;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [31:0]           half_m;
   logic [31:0]           eff_m1;
   logic [DELAY_BITS-1:0] hold_load;
   logic                  do_enter;
   phase_type             enter_ph;

   // effective hold length, zero taken as one tick
   assign half_m    = {16'd0, half_period} & DelayMask;
   assign eff_m1    = (half_m == 32'd0) ? 32'd0 : half_m - 32'd1;
   assign hold_load = eff_m1[DELAY_BITS-1:0];

   // take the next tick when the output register is free or being drained
   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   // one sequencer step per tick
   always_comb begin
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      hold_in    = hold_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      ack_in     = ack_ff;
      busy_in    = busy_ff;
      read_in    = read_ff;
      done       = 1'b0;
      do_enter   = 1'b0;
      enter_ph   = PH_IDLE;

      if (!busy_ff) begin
         // command accepted only while idle
         if (pop_entry.cmd != CMD_NONE) begin
            busy_in  = 1'b1;
            bit_in   = 3'd0;
            do_enter = 1'b1;
            case (pop_entry.cmd)
               CMD_START: enter_ph = PH_ST1;
               CMD_STOP:  enter_ph = PH_SP1;
               CMD_WRITE: begin
                  shift_in = pop_entry.data_byte;
                  enter_ph = PH_WR_A;
               end
               default: begin
                  shift_in   = 8'd0;
                  sda_in_lvl = 1'b1;
                  enter_ph   = PH_RD_A;
               end
            endcase
         end
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - {{(DELAY_BITS-1){1'b0}}, 1'b1};
      end else begin
         case (phase_ff)
            PH_ST1: begin do_enter = 1'b1; enter_ph = PH_ST2; end
            PH_ST2: begin do_enter = 1'b1; enter_ph = PH_ST3; end
            PH_ST3: begin scl_in = 1'b0; done = 1'b1; end
            PH_SP1: begin do_enter = 1'b1; enter_ph = PH_SP2; end
            PH_SP2: begin do_enter = 1'b1; enter_ph = PH_SP3; end
            PH_SP3: begin sda_in_lvl = 1'b1; done = 1'b1; end
            PH_WR_A: begin do_enter = 1'b1; enter_ph = PH_WR_B; end
            PH_WR_B: begin do_enter = 1'b1; enter_ph = PH_WR_C; end
            PH_WR_C: begin
               shift_in = {shift_ff[6:0], 1'b0};
               do_enter = 1'b1;
               if (bit_ff == 3'd7) begin
                  bit_in   = 3'd0;
                  enter_ph = PH_WA1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  enter_ph = PH_WR_A;
               end
            end
            PH_WA1: begin do_enter = 1'b1; enter_ph = PH_WA2; end
            PH_WA2: begin do_enter = 1'b1; enter_ph = PH_WA3; end
            PH_WA3: begin
               ack_in   = pop_entry.sda_in;
               do_enter = 1'b1;
               enter_ph = PH_WA4;
            end
            PH_WA4: begin scl_in = 1'b0; done = 1'b1; end
            PH_RD_A: begin
               shift_in = {shift_ff[6:0], pop_entry.sda_in};
               if (bit_ff == 3'd7) begin
                  bit_in  = 3'd0;
                  scl_in  = 1'b0;
                  read_in = {shift_ff[6:0], pop_entry.sda_in};
                  done    = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  do_enter = 1'b1;
                  enter_ph = PH_RD_B;
               end
            end
            PH_RD_B: begin do_enter = 1'b1; enter_ph = PH_RD_A; end
            default: done = 1'b1;
         endcase
      end

      // sequence end
      if (done) begin
         phase_in = PH_IDLE;
         busy_in  = 1'b0;
         hold_in  = '0;
      end

      // entering a new phase loads the hold and sets its levels
      if (do_enter) begin
         phase_in = enter_ph;
         hold_in  = hold_load;
         case (enter_ph)
            PH_ST1:  begin scl_in = 1'b0; sda_in_lvl = 1'b1; end
            PH_ST2:  scl_in = 1'b1;
            PH_ST3:  sda_in_lvl = 1'b0;
            PH_SP1:  scl_in = 1'b0;
            PH_SP2:  sda_in_lvl = 1'b0;
            PH_SP3:  scl_in = 1'b1;
            PH_WR_A: scl_in = 1'b0;
            PH_WR_B: sda_in_lvl = shift_in[7];
            PH_WR_C: scl_in = 1'b1;
            PH_WA1:  scl_in = 1'b0;
            PH_WA2:  sda_in_lvl = 1'b1;
            PH_WA3:  scl_in = 1'b1;
            PH_RD_A: scl_in = 1'b1;
            PH_RD_B: scl_in = 1'b0;
            default: scl_in = scl_in;
         endcase
      end
   end

   // sequencer state, advanced once per popped tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         hold_ff  <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b1;
         busy_ff  <= 1'b0;
         read_ff  <= 8'd0;
      end else if (pop) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         hold_ff  <= hold_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         ack_ff   <= ack_in;
         busy_ff  <= busy_in;
         read_ff  <= read_in;
      end
   end

   // output register
   always_comb begin
      rsp_data_in.scl       = scl_in;
      rsp_data_in.sda_out   = sda_in_lvl;
      rsp_data_in.busy_res  = busy_in;
      rsp_data_in.done_res  = done;
      rsp_data_in.ack_bit   = ack_in;
      rsp_data_in.read_data = read_in;
      rsp_valid_in          = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/i2c_master_byte_engine_core.sv
`default_nettype none

// Bit-banged I2C master that advances one bus tick per request transaction and returns
// one response per tick with the SCL and SDA drive levels, busy and done flags, the last
// acknowledge bit and the last read byte. Commands (start, stop, write byte, read byte)
// ride on a tick and are taken only while idle; each level step is held for half_period
// ticks (zero acts as one). half_period is written through csr_wr_en/csr_wr_data; the
// user must write it only while idle, as the block itself does not enforce this. A front
// stage classifies each tick into a two-entry queue and a back-end sequencer executes
// one tick per clock cycle into an output register while that register is free or being
// drained, so the block sustains one transaction per cycle unless rsp_stall holds it; a
// response passes through the queue slot and then the output register before it is shown.
module i2c_master_byte_engine_core #(
   parameter int DELAY_BITS = i2cbe_pkg::DelayBitsDefault
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  i2cbe_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output i2cbe_pkg::rsp_type       rsp_data,
   input  wire  logic               csr_wr_en,
   input  wire  logic [15:0]        csr_wr_data
);
   import i2cbe_pkg::*;

   logic [15:0]  half_period_ff, half_period_in;
   q_status_type q_status;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    pop_entry;

   // half period register
   assign half_period_in = csr_wr_en ? csr_wr_data : half_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HalfPeriodReset;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   i2cbe_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   i2cbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   i2cbe_back #(
      .DELAY_BITS (DELAY_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .q_status    (q_status),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // an accepted transaction reaches the response register
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("accepted transaction did not reach the response side");

   // a finishing tick always reports the sequence as no longer busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   // the back end only pops when the queue holds an entry
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire
